/* hw/rtl/aoc_pkg.sv */
// aoc_pkg: shared widths, types and helpers for the box overlap classifier
// no dependencies
package aoc_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned PushW  = CoordW + 1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [PushW-1:0]  push_t;
  typedef logic [PushW-1:0]         push_mag_t;

  // per-axis classification handed to the top level
  typedef struct packed {
    logic      hit;
    logic      far_edge;
    logic      near_edge;
    push_t     d_far;
    push_t     d_near;
    push_mag_t mag_far;
    push_mag_t mag_near;
  } axis_res_t;

  function automatic push_mag_t push_mag(input push_t v);
    push_t neg;
    neg = -v;
    return v[PushW-1] ? push_mag_t'(neg) : push_mag_t'(v);
  endfunction

endpackage

/* hw/rtl/aoc_axis.sv */
// aoc_axis: overlap, edge crossing and push-out candidates for one axis
// depends on aoc_pkg
module aoc_axis import aoc_pkg::*; (
  input  coord_t    a0_i,
  input  coord_t    a1_i,
  input  coord_t    b0_i,
  input  coord_t    b1_i,
  output axis_res_t res_o
);

  logic contained, covers, cross_far, cross_near, hit;
  push_t d_far, d_near;

  assign contained  = (a0_i >= b0_i) && (a1_i <= b1_i);
  assign covers     = (a0_i <= b0_i) && (a1_i >= b1_i);
  assign cross_far  = (a0_i < b1_i) && (a1_i > b1_i);
  assign cross_near = (a0_i < b0_i) && (a1_i > b0_i);
  assign hit        = contained || covers || cross_far || cross_near;

  // exact 33-bit differences
  assign d_far  = push_t'({b1_i[CoordW-1], b1_i}) - push_t'({a0_i[CoordW-1], a0_i});
  assign d_near = push_t'({b0_i[CoordW-1], b0_i}) - push_t'({a1_i[CoordW-1], a1_i});

  always_comb begin
    res_o.hit       = hit;
    res_o.far_edge  = hit && cross_far;
    res_o.near_edge = hit && !cross_far && cross_near;
    res_o.d_far     = d_far;
    res_o.d_near    = d_near;
    res_o.mag_far   = push_mag(d_far);
    res_o.mag_near  = push_mag(d_near);
  end

endmodule

/* hw/rtl/aabb_overlap_classify_unit.sv */
// aabb_overlap_classify_unit: two-box overlap test with minimum push-out
// depends on aoc_pkg and aoc_axis
//
// usage:
// - input channel: in_valid_i / in_stall_o carries the corners of boxes a and b;
//   a transaction completes on a rising edge with in_valid_i high and in_stall_o low
// - output channel: out_valid_o / out_stall_i carries hit flags, edge flags,
//   axis marks and signed push-out distances, one result per input transaction
// - the path is an input register, then one pass of compare and
//   subtract logic per axis feeding the result register
// - throughput is one transaction per cycle while out_stall_i is low; the input register
//   can still take an item while a finished result waits in the result register
// - when out_stall_i is high with a result waiting, the result holds and the
//   input register fills; in_stall_o rises only when both stages are full
// - reset clears both valid flags; no result is lost or repeated across a stall
// - push values are zero and both marks are low unless both axes overlap
module aabb_overlap_classify_unit import aoc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] a_x_min_i,
  input  logic signed [CoordW-1:0] a_y_min_i,
  input  logic signed [CoordW-1:0] a_x_max_i,
  input  logic signed [CoordW-1:0] a_y_max_i,
  input  logic signed [CoordW-1:0] b_x_min_i,
  input  logic signed [CoordW-1:0] b_y_min_i,
  input  logic signed [CoordW-1:0] b_x_max_i,
  input  logic signed [CoordW-1:0] b_y_max_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     hit_x_o,
  output logic                     hit_y_o,
  output logic                     edge_right_o,
  output logic                     edge_left_o,
  output logic                     edge_bottom_o,
  output logic                     edge_top_o,
  output logic                     push_x_marked_o,
  output logic                     push_y_marked_o,
  output logic signed [PushW-1:0]  push_x_o,
  output logic signed [PushW-1:0]  push_y_o
);

  // input register
  logic   s1_valid_q, s1_valid_d;
  coord_t ax0_q, ay0_q, ax1_q, ay1_q, bx0_q, by0_q, bx1_q, by1_q;
  logic   in_load, s1_stall, out_load;

  // result register
  logic      out_valid_q, out_valid_d;
  logic      hit_x_q, hit_y_q, er_q, el_q, eb_q, et_q, mx_q, my_q;
  push_t     px_q, py_q;
  logic      mx_d, my_d, full_hit;
  push_t     px_d, py_d;
  push_mag_t px_mag, py_mag;

  axis_res_t x_res, y_res;

  assign s1_stall   = out_valid_q && out_stall_i;
  assign in_stall_o = s1_valid_q && s1_stall;
  assign in_load    = in_valid_i && !in_stall_o;
  assign out_load   = s1_valid_q && !s1_stall;

  assign s1_valid_d  = in_load ? 1'b1 : (s1_stall ? s1_valid_q : 1'b0);
  assign out_valid_d = out_load ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      ax0_q <= a_x_min_i;
      ay0_q <= a_y_min_i;
      ax1_q <= a_x_max_i;
      ay1_q <= a_y_max_i;
      bx0_q <= b_x_min_i;
      by0_q <= b_y_min_i;
      bx1_q <= b_x_max_i;
      by1_q <= b_y_max_i;
    end
  end

  aoc_axis u_axis_x (
    .a0_i  (ax0_q),
    .a1_i  (ax1_q),
    .b0_i  (bx0_q),
    .b1_i  (bx1_q),
    .res_o (x_res)
  );

  aoc_axis u_axis_y (
    .a0_i  (ay0_q),
    .a1_i  (ay1_q),
    .b0_i  (by0_q),
    .b1_i  (by1_q),
    .res_o (y_res)
  );

  // x prefers the far candidate only when strictly smaller, y the near one
  always_comb begin
    full_hit = x_res.hit && y_res.hit;
    if (x_res.mag_far < x_res.mag_near) begin
      px_mag = x_res.mag_far;
      px_d   = x_res.d_far;
    end else begin
      px_mag = x_res.mag_near;
      px_d   = x_res.d_near;
    end
    if (y_res.mag_near < y_res.mag_far) begin
      py_mag = y_res.mag_near;
      py_d   = y_res.d_near;
    end else begin
      py_mag = y_res.mag_far;
      py_d   = y_res.d_far;
    end
    mx_d = full_hit && (px_mag <= py_mag);
    my_d = full_hit && (py_mag <= px_mag);
    if (!full_hit) begin
      px_d = '0;
      py_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      hit_x_q <= x_res.hit;
      hit_y_q <= y_res.hit;
      er_q    <= x_res.far_edge;
      el_q    <= x_res.near_edge;
      eb_q    <= y_res.far_edge;
      et_q    <= y_res.near_edge;
      mx_q    <= mx_d;
      my_q    <= my_d;
      px_q    <= px_d;
      py_q    <= py_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_x_o         = hit_x_q;
  assign hit_y_o         = hit_y_q;
  assign edge_right_o    = er_q;
  assign edge_left_o     = el_q;
  assign edge_bottom_o   = eb_q;
  assign edge_top_o      = et_q;
  assign push_x_marked_o = mx_q;
  assign push_y_marked_o = my_q;
  assign push_x_o        = px_q;
  assign push_y_o        = py_q;

  // no input is taken while both stages are full and the output is stalled
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("input accepted with both stages full");

  // a held result survives into the next cycle
  a_result_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(px_q) && $stable(py_q))
    else $error("stalled result lost or changed");

  // without overlap on both axes nothing is pushed or marked
  a_no_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !(hit_x_q && hit_y_q) |->
      px_q == '0 && py_q == '0 && !mx_q && !my_q)
    else $error("push reported without full overlap");

  // with full overlap at least one axis is marked, and edge flags are exclusive
  a_marks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((hit_x_q && hit_y_q) == (mx_q || my_q)) &&
      !(er_q && el_q) && !(eb_q && et_q))
    else $error("inconsistent marks or edge flags");

endmodule
